// ===== hdl/mkdr_pkg.sv =====
`default_nettype none

package mkdr_pkg;

   localparam int unsigned ActionWidth = 2;
   localparam int unsigned ScanWidth   = 6;
   localparam int unsigned KeyWidth    = 3;
   localparam int unsigned CsrWidth    = 8;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [ActionWidth-1:0] ACT_POLL       = 2'd0;
   localparam logic [ActionWidth-1:0] ACT_TICK_DEB   = 2'd1;
   localparam logic [ActionWidth-1:0] ACT_TICK_LONG  = 2'd2;

   localparam logic [KeyWidth-1:0] KEY_NONE   = 3'd0;
   localparam logic [KeyWidth-1:0] KEY_SCAN   = 3'd1;
   localparam logic [KeyWidth-1:0] KEY_UP     = 3'd2;
   localparam logic [KeyWidth-1:0] KEY_CONFIG = 3'd3;
   localparam logic [KeyWidth-1:0] KEY_BAND   = 3'd4;
   localparam logic [KeyWidth-1:0] KEY_MODE   = 3'd5;
   localparam logic [KeyWidth-1:0] KEY_DOWN   = 3'd6;
   localparam logic [KeyWidth-1:0] KEY_UPDOWN = 3'd7;

   localparam int unsigned BIT_SCAN   = 0;
   localparam int unsigned BIT_UP     = 1;
   localparam int unsigned BIT_CONFIG = 2;
   localparam int unsigned BIT_BAND   = 3;
   localparam int unsigned BIT_MODE   = 4;
   localparam int unsigned BIT_DOWN   = 5;

   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_TIME   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_PRESS_TIME = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_INTERVAL = 2'd2;

   localparam logic [CsrWidth-1:0] DEBOUNCE_TIME_RESET   = 8'd10;
   localparam logic [CsrWidth-1:0] LONG_PRESS_TIME_RESET = 8'd2;
   localparam logic [CsrWidth-1:0] REPEAT_INTERVAL_RESET = 8'd4;

   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [ScanWidth-1:0]   first_scan;
      logic [ScanWidth-1:0]   second_scan;
   } req_payload_type;

   typedef struct packed {
      logic [KeyWidth-1:0] key_code;
      logic                long_press;
      logic                click;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== hdl/mkdr_key_encode.sv =====
`default_nettype none

module mkdr_key_encode
   import mkdr_pkg::*;
(
   input  wire logic [ScanWidth-1:0] contacts,
   output logic      [KeyWidth-1:0]  key_code
);

   logic [KeyWidth-1:0] base_key;

   // later contacts win
   always_comb begin
      base_key = KEY_NONE;
      if (contacts[BIT_SCAN])   base_key = KEY_SCAN;
      if (contacts[BIT_UP])     base_key = KEY_UP;
      if (contacts[BIT_CONFIG]) base_key = KEY_CONFIG;
      if (contacts[BIT_BAND])   base_key = KEY_BAND;
      if (contacts[BIT_MODE])   base_key = KEY_MODE;
   end

   always_comb begin
      key_code = base_key;
      if (contacts[BIT_DOWN]) begin
         key_code = (base_key == KEY_UP) ? KEY_UPDOWN : KEY_DOWN;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/matrix_keypad_debounce_repeat.sv =====
// a poll passes the input register, then the result register; it waits while the output stalls
// throughput: one item per cycle while no poll waits on a stalled output; ticks produce no result
// reset: synchronous, clears counters, last key, long-press flag and both valid stages,
// and loads debounce_time 10, long_press_time 2, repeat_interval 4
`default_nettype none

module matrix_keypad_debounce_repeat
   import mkdr_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_payload,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_payload,

   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrWidth-1:0]    csr_wdata
);

   localparam int unsigned CmpWidth = (COUNTER_BITS > CsrWidth) ? COUNTER_BITS : CsrWidth;
   localparam logic [CmpWidth-1:0] CntMax = CmpWidth'({COUNTER_BITS{1'b1}});

   function automatic logic [COUNTER_BITS-1:0] clamp_load(input logic [CsrWidth-1:0] v);
      logic [CmpWidth-1:0] ext;
      ext = CmpWidth'(v);
      clamp_load = (ext > CntMax) ? CntMax[COUNTER_BITS-1:0] : ext[COUNTER_BITS-1:0];
   endfunction

   logic [CsrWidth-1:0]     debounce_time_ff;
   logic [CsrWidth-1:0]     long_press_time_ff;
   logic [CsrWidth-1:0]     repeat_interval_ff;

   logic                    in_valid_ff;
   logic                    in_valid_in;
   req_payload_type         in_payload_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_payload_type         rsp_payload_ff;
   rsp_payload_type         rsp_payload_in;

   logic [COUNTER_BITS-1:0] debounce_count_ff;
   logic [COUNTER_BITS-1:0] debounce_count_in;
   logic [COUNTER_BITS-1:0] hold_count_ff;
   logic [COUNTER_BITS-1:0] hold_count_in;
   logic [KeyWidth-1:0]     last_key_ff;
   logic [KeyWidth-1:0]     last_key_in;
   logic                    long_flag_ff;
   logic                    long_flag_in;

   logic [KeyWidth-1:0]     first_key;
   logic [KeyWidth-1:0]     second_key;
   logic [KeyWidth-1:0]     key;
   logic                    click;
   logic                    is_poll;
   logic                    out_free;
   logic                    fire;

   mkdr_key_encode u_encode_first (
      .contacts (in_payload_ff.first_scan),
      .key_code (first_key)
   );

   mkdr_key_encode u_encode_second (
      .contacts (in_payload_ff.second_scan),
      .key_code (second_key)
   );

   assign is_poll   = (in_payload_ff.action == ACT_POLL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!is_poll || out_free);
   assign req_stall = in_valid_ff && !fire;

   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !fire);

   always_comb begin
      debounce_count_in = debounce_count_ff;
      hold_count_in     = hold_count_ff;
      last_key_in       = last_key_ff;
      long_flag_in      = long_flag_ff;
      key               = KEY_NONE;
      click             = 1'b0;
      if (fire) begin
         unique case (in_payload_ff.action)
            ACT_TICK_DEB: begin
               if (debounce_count_ff != '0) debounce_count_in = debounce_count_ff - 1'b1;
            end
            ACT_TICK_LONG: begin
               if (hold_count_ff != '0) hold_count_in = hold_count_ff - 1'b1;
            end
            ACT_POLL: begin
               if (debounce_count_ff == '0) begin
                  key = (first_key == second_key) ? first_key : KEY_NONE;
                  if (key != KEY_NONE) begin
                     click             = 1'b1;
                     debounce_count_in = clamp_load(debounce_time_ff);
                     if (key == last_key_ff) begin
                        if (hold_count_ff == '0) begin
                           // held up or down auto-repeats
                           if (key == KEY_UP || key == KEY_DOWN) begin
                              debounce_count_in = clamp_load(repeat_interval_ff);
                           end
                           long_flag_in = 1'b1;
                        end
                     end else begin
                        hold_count_in = clamp_load(long_press_time_ff);
                        last_key_in   = key;
                        long_flag_in  = 1'b0;
                     end
                  end else begin
                     last_key_in = KEY_NONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_payload_in.key_code   = key;
      rsp_payload_in.long_press = long_flag_in;
      rsp_payload_in.click      = click;
   end

   assign rsp_valid_in = (fire && is_poll) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff   <= DEBOUNCE_TIME_RESET;
         long_press_time_ff <= LONG_PRESS_TIME_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME:   debounce_time_ff   <= csr_wdata;
            CSR_LONG_PRESS_TIME: long_press_time_ff <= csr_wdata;
            CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         debounce_count_ff <= '0;
         hold_count_ff     <= '0;
         last_key_ff       <= KEY_NONE;
         long_flag_ff      <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         debounce_count_ff <= debounce_count_in;
         hold_count_ff     <= hold_count_in;
         last_key_ff       <= last_key_in;
         long_flag_ff      <= long_flag_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_payload_ff <= req_payload;
      if (fire && is_poll) rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   import mkdr_pkg::*;

   localparam int unsigned CounterBits = 8;
   localparam int unsigned CntMax = (1 << CounterBits) - 1;
   localparam logic [ActionWidth-1:0] ACT_UNUSED = 2'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_UNMAPPED = 2'd3;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0] csr_wdata = '0;

   matrix_keypad_debounce_repeat #(.COUNTER_BITS(CounterBits)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // keypad state as the block should hold it
   logic [CsrWidth-1:0] debounce_time_q;
   logic [CsrWidth-1:0] long_press_time_q;
   logic [CsrWidth-1:0] repeat_interval_q;
   logic [CounterBits-1:0] debounce_left;
   logic [CounterBits-1:0] hold_left;
   logic [KeyWidth-1:0] held_key;
   logic long_held;

   rsp_payload_type expected_keys[$];
   rsp_payload_type want;
   int errors = 0;
   bit quiet = 1'b0;
   int hold_off_cycles = 0;
   logic [ScanWidth-1:0] held_contacts = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 400000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [KeyWidth-1:0] scan_to_key(input logic [ScanWidth-1:0] contacts);
      logic [KeyWidth-1:0] k;
      k = KEY_NONE;
      if (contacts[BIT_SCAN]) k = KEY_SCAN;
      if (contacts[BIT_UP]) k = KEY_UP;
      if (contacts[BIT_CONFIG]) k = KEY_CONFIG;
      if (contacts[BIT_BAND]) k = KEY_BAND;
      if (contacts[BIT_MODE]) k = KEY_MODE;
      if (contacts[BIT_DOWN]) k = (k == KEY_UP) ? KEY_UPDOWN : KEY_DOWN;
      return k;
   endfunction

   function automatic logic [CounterBits-1:0] count_load(input logic [CsrWidth-1:0] v);
      if (v > CntMax) return CounterBits'(CntMax);
      return CounterBits'(v);
   endfunction

   task automatic qualify_key(input req_payload_type item);
      logic [KeyWidth-1:0] k1;
      logic [KeyWidth-1:0] k2;
      rsp_payload_type r;
      r = '0;
      case (item.action)
         ACT_TICK_DEB: if (debounce_left != 0) debounce_left--;
         ACT_TICK_LONG: if (hold_left != 0) hold_left--;
         ACT_POLL: begin
            if (debounce_left == 0) begin
               k1 = scan_to_key(item.first_scan);
               k2 = scan_to_key(item.second_scan);
               r.key_code = (k1 == k2) ? k1 : KEY_NONE;
               if (r.key_code != KEY_NONE) begin
                  r.click = 1'b1;
                  debounce_left = count_load(debounce_time_q);
                  if (r.key_code == held_key) begin
                     if (hold_left == 0) begin
                        if (r.key_code == KEY_UP || r.key_code == KEY_DOWN)
                           debounce_left = count_load(repeat_interval_q);
                        long_held = 1'b1;
                     end
                  end else begin
                     hold_left = count_load(long_press_time_q);
                     held_key = r.key_code;
                     long_held = 1'b0;
                  end
               end else begin
                  held_key = KEY_NONE;
               end
            end
            r.long_press = long_held;
            expected_keys.push_back(r);
         end
         default: ;
      endcase
   endtask

   // one transfer on the request side; valid stays up for a following item
   task automatic send_item(input req_payload_type item);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      qualify_key(item);
   endtask

   task automatic send_poll(input logic [ScanWidth-1:0] s1, input logic [ScanWidth-1:0] s2);
      req_payload_type item;
      item.action = ACT_POLL;
      item.first_scan = s1;
      item.second_scan = s2;
      send_item(item);
   endtask

   task automatic send_tick(input logic [ActionWidth-1:0] act);
      req_payload_type item;
      item.action = act;
      item.first_scan = 6'($urandom_range(0, 63));
      item.second_scan = 6'($urandom_range(0, 63));
      send_item(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [CsrWidth-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_TIME: debounce_time_q = val;
         CSR_LONG_PRESS_TIME: long_press_time_q = val;
         CSR_REPEAT_INTERVAL: repeat_interval_q = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [CsrWidth-1:0] deb, input logic [CsrWidth-1:0] lng,
                             input logic [CsrWidth-1:0] rep);
      drain();
      write_reg(CSR_DEBOUNCE_TIME, deb);
      write_reg(CSR_LONG_PRESS_TIME, lng);
      write_reg(CSR_REPEAT_INTERVAL, rep);
      write_reg(CSR_UNMAPPED, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [ScanWidth-1:0] random_contacts();
      case ($urandom_range(0, 4))
         0: return 6'(1 << $urandom_range(0, 5));
         1: return 6'((1 << BIT_UP) | (1 << BIT_DOWN));
         2: return '0;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   // mostly a held key polled between ticks, with bounce and noise mixed in
   task automatic send_random_item();
      req_payload_type item;
      int pick;
      pick = $urandom_range(0, 99);
      item.action = ACT_POLL;
      item.first_scan = 6'($urandom_range(0, 63));
      item.second_scan = 6'($urandom_range(0, 63));
      if (pick < 50) begin
         if ($urandom_range(0, 7) == 0) held_contacts = random_contacts();
         if (pick < 40) begin
            item.first_scan = held_contacts;
            item.second_scan = held_contacts;
         end else if (pick < 45) begin
            item.first_scan = held_contacts;
         end
      end else if (pick < 80) begin
         item.action = ACT_TICK_DEB;
      end else if (pick < 97) begin
         item.action = ACT_TICK_LONG;
      end else begin
         item.action = ACT_UNUSED;
      end
      send_item(item);
   endtask

   function automatic logic [CsrWidth-1:0] random_setting();
      if ($urandom_range(0, 9) == 0) return 8'd255;
      return 8'($urandom_range(0, 6));
   endfunction

   task automatic test_key_encoding();
      set_timing(8'd0, 8'd255, 8'd0);
      send_poll(6'h01, 6'h01);
      send_poll(6'h02, 6'h02);
      send_poll(6'h04, 6'h04);
      send_poll(6'h08, 6'h08);
      send_poll(6'h10, 6'h10);
      send_poll(6'h20, 6'h20);
      send_poll(6'h22, 6'h22);
      send_poll(6'h3f, 6'h3f);
      send_poll(6'h00, 6'h00);
      send_poll(6'h04, 6'h08);
      send_tick(ACT_UNUSED);
   endtask

   task automatic test_hold_repeat_release();
      set_timing(8'd2, 8'd1, 8'd3);
      send_poll(6'h02, 6'h02);
      send_poll(6'h02, 6'h02);
      repeat (3) send_tick(ACT_TICK_DEB);
      repeat (2) send_tick(ACT_TICK_LONG);
      send_poll(6'h02, 6'h02);
      send_poll(6'h00, 6'h00);
      repeat (3) send_tick(ACT_TICK_DEB);
      send_poll(6'h00, 6'h00);
      send_poll(6'h10, 6'h10);
   endtask

   task automatic test_output_backpressure();
      set_timing(8'd0, 8'd3, 8'd1);
      hold_off_cycles = 60;
      repeat (30) send_random_item();
      drain();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 0) set_timing(8'd0, 8'd0, 8'd0);
         else if (phase == 1) set_timing(8'd255, 8'd255, 8'd255);
         else set_timing(random_setting(), random_setting(), random_setting());
         repeat (100) send_random_item();
      end
   endtask

   task automatic test_steady_flow();
      set_timing(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
      quiet = 1'b1;
      repeat (100) send_random_item();
      drain();
   endtask

   // receiver side stall pattern
   initial begin : rsp_stall_gen
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_keys.size() == 0) begin
            $error("result with no expectation: key_code %0d", rsp_payload.key_code);
            errors++;
         end else begin
            want = expected_keys.pop_front();
            if (rsp_payload.key_code !== want.key_code) begin
               $error("key_code expected %0d actual %0d", want.key_code, rsp_payload.key_code);
               errors++;
            end
            if (rsp_payload.long_press !== want.long_press) begin
               $error("long_press expected %0d actual %0d", want.long_press,
                      rsp_payload.long_press);
               errors++;
            end
            if (rsp_payload.click !== want.click) begin
               $error("click expected %0d actual %0d", want.click, rsp_payload.click);
               errors++;
            end
         end
      end
   end

   initial begin
      debounce_time_q = DEBOUNCE_TIME_RESET;
      long_press_time_q = LONG_PRESS_TIME_RESET;
      repeat_interval_q = REPEAT_INTERVAL_RESET;
      debounce_left = '0;
      hold_left = '0;
      held_key = KEY_NONE;
      long_held = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_key_encoding();
      test_hold_repeat_release();
      test_output_backpressure();
      test_random_settings();
      test_steady_flow();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
